// ===== sv/fbde_pkg.sv =====
`timescale 1ns / 1ps

package fbde_pkg;

    // Largest area extent that a command may ask for.
    localparam int MAX_DIM = 2048;
    localparam int PIXEL_BITS_DEFAULT = 16;

    localparam int DIM_W = 12;
    localparam int POS_W = 11;
    localparam int COORD_W = 14;
    localparam int ADDR_W = 22;
    localparam int REG_INDEX_W = 3;

    localparam logic [DIM_W:0] MAX_DIM_C = (DIM_W + 1)'(MAX_DIM);

    localparam logic ACTION_LOAD = 1'b0;
    localparam logic ACTION_STEP = 1'b1;

    localparam logic [REG_INDEX_W-1:0] REG_NORMAL_WIDTH    = 3'd0;
    localparam logic [REG_INDEX_W-1:0] REG_NORMAL_HEIGHT   = 3'd1;
    localparam logic [REG_INDEX_W-1:0] REG_ROTATED_WIDTH   = 3'd2;
    localparam logic [REG_INDEX_W-1:0] REG_ROTATED_HEIGHT  = 3'd3;
    localparam logic [REG_INDEX_W-1:0] REG_TRANSPARENT_KEY = 3'd4;

    localparam logic [DIM_W-1:0] NORMAL_WIDTH_RST   = 12'd800;
    localparam logic [DIM_W-1:0] NORMAL_HEIGHT_RST  = 12'd480;
    localparam logic [DIM_W-1:0] ROTATED_WIDTH_RST  = 12'd480;
    localparam logic [DIM_W-1:0] ROTATED_HEIGHT_RST = 12'd800;

    typedef enum logic [2:0] {
        OP_FILL     = 3'd0,
        OP_MESH     = 3'd1,
        OP_ROW_LINE = 3'd2,
        OP_COL_LINE = 3'd3,
        OP_BLIT     = 3'd4
    } op_t;

    typedef struct packed {
        logic [DIM_W-1:0] outer;
        logic [DIM_W-1:0] inner;
    } limits_t;

    // Control and coordinates of one write between the two pipeline stages.
    typedef struct packed {
        logic               write_enable;
        logic               last;
        logic               rejected;
        logic               rotated;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
    } stage_t;

    function automatic limits_t area_limits(op_t op, logic rot,
                                            logic [DIM_W-1:0] w,
                                            logic [DIM_W-1:0] h);
        limits_t lim;
        lim.outer = h;
        lim.inner = w;
        case (op)
            OP_FILL: begin
                lim.outer = rot ? w : h;
                lim.inner = rot ? h : w;
            end
            OP_MESH: begin
                lim.outer = h;
                lim.inner = w >> 1;
            end
            OP_ROW_LINE, OP_COL_LINE: begin
                lim.outer = w;
                lim.inner = h;
            end
            default: begin
                lim.outer = h;
                lim.inner = w;
            end
        endcase
        return lim;
    endfunction

endpackage

// ===== sv/framebuffer_draw_engine.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake           Item
// s_        in         s_valid / s_ready   load command or one pixel step
// m_        out        m_valid / m_ready   one pixel write or one rejection
// cfg_      in         cfg_wr_en           register write, no wait
//
// Two stages: the first advances the command counters and forms the pixel
// coordinates, the second does the one address multiply and add.
// An item can be accepted every cycle unless the output stalls the stages.
// A stalled m_ready holds both stages, and s_ready drops once they are full.
// Reset is synchronous on aresetn and returns the engine to idle.

module framebuffer_draw_engine #(
    parameter int PIXEL_BITS = fbde_pkg::PIXEL_BITS_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                cfg_wr_en,
    input  logic [fbde_pkg::REG_INDEX_W-1:0]    cfg_index,
    input  logic [((PIXEL_BITS > fbde_pkg::DIM_W) ? PIXEL_BITS
                   : fbde_pkg::DIM_W)-1:0]      cfg_wr_data,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_action,
    input  logic [2:0]                          s_operation,
    input  logic                                s_rotated,
    input  logic [fbde_pkg::POS_W-1:0]          s_pos_x,
    input  logic [fbde_pkg::POS_W-1:0]          s_pos_y,
    input  logic [fbde_pkg::DIM_W-1:0]          s_extent_w,
    input  logic [fbde_pkg::DIM_W-1:0]          s_extent_h,
    input  logic [PIXEL_BITS-1:0]               s_pixel_value,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_write_enable,
    output logic [fbde_pkg::ADDR_W-1:0]         m_write_address,
    output logic [PIXEL_BITS-1:0]               m_write_pixel,
    output logic                                m_last,
    output logic                                m_rejected
);

    localparam int DW = fbde_pkg::DIM_W;
    localparam int CW = fbde_pkg::COORD_W;
    localparam int AW = fbde_pkg::ADDR_W;

    // Configuration registers.
    logic [DW-1:0]         normal_width_reg, normal_height_reg;
    logic [DW-1:0]         rotated_width_reg, rotated_height_reg;
    logic [PIXEL_BITS-1:0] transparent_key_reg;

    // Command state.
    logic                  busy_reg, busy_next;
    fbde_pkg::op_t         op_code_reg, op_code_next;
    logic                  rotated_mode_reg, rotated_mode_next;
    logic [fbde_pkg::POS_W-1:0] origin_col_reg, origin_col_next;
    logic [fbde_pkg::POS_W-1:0] origin_row_reg, origin_row_next;
    logic [DW-1:0]         area_width_reg, area_width_next;
    logic [DW-1:0]         area_height_reg, area_height_next;
    logic [PIXEL_BITS-1:0] fill_colour_reg, fill_colour_next;
    logic [DW-1:0]         outer_count_reg, outer_count_next;
    logic [DW-1:0]         inner_count_reg, inner_count_next;
    logic                  mesh_phase_reg, mesh_phase_next;

    // Pipeline registers.
    logic                  s1_valid_reg;
    fbde_pkg::stage_t      s1_reg;
    logic [PIXEL_BITS-1:0] s1_pixel_reg;
    logic                  m_valid_reg;
    logic                  m_write_enable_reg, m_last_reg, m_rejected_reg;
    logic [AW-1:0]         m_write_address_reg;
    logic [PIXEL_BITS-1:0] m_write_pixel_reg;

    logic                  s_fire, out_ready;
    logic                  res_valid;
    fbde_pkg::stage_t      res;
    logic [PIXEL_BITS-1:0] res_pixel;
    fbde_pkg::limits_t     cur_lim, new_lim;
    logic                  bad;
    logic [DW-1:0]         inner_inc, outer_inc;

    logic [CW-1:0]         mul_a;
    logic [DW-1:0]         mul_b;
    logic [CW+DW-1:0]      product;
    logic [AW-1:0]         offset, address;

    assign out_ready = !m_valid_reg || m_ready;
    assign s_ready   = !s1_valid_reg || out_ready;
    assign s_fire    = s_valid && s_ready;

    assign cur_lim = fbde_pkg::area_limits(op_code_reg, rotated_mode_reg,
                                           area_width_reg, area_height_reg);
    assign new_lim = fbde_pkg::area_limits(fbde_pkg::op_t'(s_operation), s_rotated,
                                           s_extent_w, s_extent_h);
    assign inner_inc = inner_count_reg + 1'b1;
    assign outer_inc = outer_count_reg + 1'b1;

    always_comb begin
        busy_next         = busy_reg;
        op_code_next      = op_code_reg;
        rotated_mode_next = rotated_mode_reg;
        origin_col_next   = origin_col_reg;
        origin_row_next   = origin_row_reg;
        area_width_next   = area_width_reg;
        area_height_next  = area_height_reg;
        fill_colour_next  = fill_colour_reg;
        outer_count_next  = outer_count_reg;
        inner_count_next  = inner_count_reg;
        mesh_phase_next   = mesh_phase_reg;
        res_valid         = 1'b0;
        res               = '0;
        res_pixel         = '0;
        bad               = 1'b0;

        if (s_fire) begin
            if (s_action == fbde_pkg::ACTION_LOAD) begin
                bad = (s_operation > fbde_pkg::OP_BLIT)
                    || ({1'b0, s_extent_w} > fbde_pkg::MAX_DIM_C)
                    || ({1'b0, s_extent_h} > fbde_pkg::MAX_DIM_C);
                // Only the area operations are checked against the buffer.
                if (!bad && (s_operation == fbde_pkg::OP_FILL
                          || s_operation == fbde_pkg::OP_MESH
                          || s_operation == fbde_pkg::OP_BLIT)) begin
                    if (s_rotated) begin
                        bad = (s_extent_w > rotated_height_reg)
                           || (s_extent_h > rotated_width_reg);
                    end else begin
                        bad = (s_extent_w > normal_width_reg)
                           || (s_extent_h > normal_height_reg);
                    end
                end
                busy_next = 1'b0;
                if (bad) begin
                    res_valid    = 1'b1;
                    res.rejected = 1'b1;
                end else begin
                    op_code_next      = fbde_pkg::op_t'(s_operation);
                    rotated_mode_next = s_rotated;
                    origin_col_next   = s_pos_x;
                    origin_row_next   = s_pos_y;
                    area_width_next   = s_extent_w;
                    area_height_next  = s_extent_h;
                    fill_colour_next  = s_pixel_value;
                    outer_count_next  = '0;
                    inner_count_next  = '0;
                    mesh_phase_next   = 1'b0;
                    busy_next = (new_lim.outer != '0) && (new_lim.inner != '0);
                end
            end else if (busy_reg) begin
                res_valid   = 1'b1;
                res.rotated = rotated_mode_reg;
                if (op_code_reg == fbde_pkg::OP_COL_LINE
                    || (op_code_reg == fbde_pkg::OP_FILL && rotated_mode_reg)) begin
                    res.col = CW'(origin_col_reg) + CW'(outer_count_reg);
                    res.row = CW'(origin_row_reg) + CW'(inner_count_reg);
                end else if (op_code_reg == fbde_pkg::OP_MESH) begin
                    res.row = CW'(origin_row_reg) + CW'(outer_count_reg);
                    res.col = CW'(origin_col_reg) + CW'(mesh_phase_reg)
                            + {1'b0, inner_count_reg, 1'b0};
                end else begin
                    res.row = CW'(origin_row_reg) + CW'(outer_count_reg);
                    res.col = CW'(origin_col_reg) + CW'(inner_count_reg);
                end

                if (op_code_reg == fbde_pkg::OP_BLIT) begin
                    res_pixel        = s_pixel_value;
                    res.write_enable = (s_pixel_value != transparent_key_reg);
                end else begin
                    res_pixel        = fill_colour_reg;
                    res.write_enable = 1'b1;
                end

                inner_count_next = inner_inc;
                if (inner_inc >= cur_lim.inner) begin
                    inner_count_next = '0;
                    outer_count_next = outer_inc;
                    mesh_phase_next  = !mesh_phase_reg;
                    if (outer_inc >= cur_lim.outer) begin
                        busy_next = 1'b0;
                        res.last  = 1'b1;
                    end
                end
            end
        end
    end

    // Second stage: one multiply and one add of an offset form the framebuffer address.
    always_comb begin
        if (s1_reg.rotated) begin
            mul_a  = s1_reg.col;
            mul_b  = rotated_width_reg;
            offset = AW'(rotated_width_reg) - AW'(1) - AW'(s1_reg.row);
        end else begin
            mul_a  = s1_reg.row;
            mul_b  = normal_width_reg;
            offset = AW'(s1_reg.col);
        end
        product = mul_a * mul_b;
        address = product[AW-1:0] + offset;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            normal_width_reg    <= fbde_pkg::NORMAL_WIDTH_RST;
            normal_height_reg   <= fbde_pkg::NORMAL_HEIGHT_RST;
            rotated_width_reg   <= fbde_pkg::ROTATED_WIDTH_RST;
            rotated_height_reg  <= fbde_pkg::ROTATED_HEIGHT_RST;
            transparent_key_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                fbde_pkg::REG_NORMAL_WIDTH:    normal_width_reg   <= cfg_wr_data[DW-1:0];
                fbde_pkg::REG_NORMAL_HEIGHT:   normal_height_reg  <= cfg_wr_data[DW-1:0];
                fbde_pkg::REG_ROTATED_WIDTH:   rotated_width_reg  <= cfg_wr_data[DW-1:0];
                fbde_pkg::REG_ROTATED_HEIGHT:  rotated_height_reg <= cfg_wr_data[DW-1:0];
                fbde_pkg::REG_TRANSPARENT_KEY: begin
                    transparent_key_reg <= cfg_wr_data[PIXEL_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg         <= 1'b0;
            op_code_reg      <= fbde_pkg::OP_FILL;
            rotated_mode_reg <= 1'b0;
            origin_col_reg   <= '0;
            origin_row_reg   <= '0;
            area_width_reg   <= '0;
            area_height_reg  <= '0;
            fill_colour_reg  <= '0;
            outer_count_reg  <= '0;
            inner_count_reg  <= '0;
            mesh_phase_reg   <= 1'b0;
            s1_valid_reg     <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            busy_reg         <= busy_next;
            op_code_reg      <= op_code_next;
            rotated_mode_reg <= rotated_mode_next;
            origin_col_reg   <= origin_col_next;
            origin_row_reg   <= origin_row_next;
            area_width_reg   <= area_width_next;
            area_height_reg  <= area_height_next;
            fill_colour_reg  <= fill_colour_next;
            outer_count_reg  <= outer_count_next;
            inner_count_reg  <= inner_count_next;
            mesh_phase_reg   <= mesh_phase_next;
            if (s_ready) begin
                s1_valid_reg <= s_fire && res_valid;
            end
            if (out_ready) begin
                m_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready) begin
            s1_reg       <= res;
            s1_pixel_reg <= res_pixel;
        end
        if (out_ready) begin
            m_write_enable_reg  <= s1_reg.write_enable;
            m_last_reg          <= s1_reg.last;
            m_rejected_reg      <= s1_reg.rejected;
            m_write_address_reg <= s1_reg.rejected ? '0 : address;
            m_write_pixel_reg   <= s1_pixel_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_write_enable  = m_write_enable_reg;
    assign m_write_address = m_write_address_reg;
    assign m_write_pixel   = m_write_pixel_reg;
    assign m_last          = m_last_reg;
    assign m_rejected      = m_rejected_reg;

    // A rejection never carries a write.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_rejected |-> !m_write_enable && !m_last && m_write_address == '0)
        else $error("rejection result carries a write");

    // While a command runs, both counters stay inside its area.
    assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> inner_count_reg < cur_lim.inner && outer_count_reg < cur_lim.outer)
        else $error("command counter beyond its limit");

    // A step that arrives while idle yields no result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_action == fbde_pkg::ACTION_STEP && !busy_reg |=> !s1_valid_reg)
        else $error("step while idle produced a result");

    // The final write of a command leaves the engine idle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && res_valid && res.last |=> !busy_reg)
        else $error("engine still busy after its last write");

    // A held result stage keeps its item until the output takes it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && !out_ready |=> s1_valid_reg && $stable(s1_reg))
        else $error("stalled item lost between stages");

endmodule
